[rtl/nearest_name_edit_distance_assert.svh]
// Assertion macros for the nearest-name block.
// Used only by the top level; no other dependencies.
`ifndef NEAREST_NAME_EDIT_DISTANCE_ASSERT_SVH
`define NEAREST_NAME_EDIT_DISTANCE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define NNED_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define NNED_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/nned_pkg.sv]
// Shared types, constants and helpers for the nearest-name block.
// No dependencies; used by the controller, datapath and top level.
package nned_pkg;

  localparam int MaxName = 64;
  localparam int LenW    = 7;
  localparam int IdxW    = 16;
  localparam int Div3Mul = 171;
  localparam int Div3Sh  = 9;

  typedef enum logic [1:0] {
    CMD_NEW  = 2'd0,
    CMD_TGT  = 2'd1,
    CMD_CHR  = 2'd2,
    CMD_END  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] character;
    logic       last;
    logic       final_candidate;
  } in_req_t;

  typedef struct packed {
    logic [IdxW-1:0] candidate_index;
    logic [LenW-1:0] distance;
    logic            too_long;
    logic            no_target;
    logic            accepted;
    logic            best_valid;
    logic [IdxW-1:0] best_index;
    logic [LenW-1:0] best_distance;
    logic            list_done;
  } out_res_t;

  // Controller to datapath.
  typedef struct packed {
    logic take;    // request accepted this cycle
    logic start;   // begin a row update
    logic row;     // row update in progress
    logic finish;  // emit result and close the candidate
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic loop_done;
    logic cand_full;
    logic last;
    logic out_free;
  } dp_stat_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) r = c + 8'h20;
    return r;
  endfunction

endpackage

[rtl/nned_ctrl.sv]
// Controller state machine for the nearest-name block.
// Depends on nned_pkg for command and status types.
module nned_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  nned_pkg::cmd_e      cmd_i,
  input  logic                last_i,
  input  nned_pkg::dp_stat_t  stat_i,
  output nned_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ROW  = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   take;

  assign in_ready_o = (state_q == ST_IDLE);
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.take   = take;
    cmd_o.row    = (state_q == ST_ROW);
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          case (cmd_i)
            nned_pkg::CMD_CHR: begin
              if (!stat_i.cand_full) begin
                cmd_o.start = 1'b1;
                state_d     = ST_ROW;
              end else if (last_i) begin
                state_d = ST_FIN;
              end
            end
            nned_pkg::CMD_END: state_d = ST_FIN;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_ROW: begin
        if (stat_i.loop_done) begin
          state_d = stat_i.last ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/nned_dp.sv]
// Datapath for the nearest-name block: target store, two row memories,
// one-column-per-cycle distance cell, best tracking and the result register.
// Depends on nned_pkg.
module nned_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nned_pkg::in_req_t   in_req_i,
  input  nned_pkg::ctrl_cmd_t cmd_i,
  output nned_pkg::dp_stat_t  stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output nned_pkg::out_res_t  out_res_o
);

  localparam int LW = nned_pkg::LenW;
  localparam int IW = nned_pkg::IdxW;

  logic [7:0]    tmem   [nned_pkg::MaxName];
  logic [LW-1:0] rl_mem [nned_pkg::MaxName+1];
  logic [LW-1:0] rb_mem [nned_pkg::MaxName+1];
  logic [nned_pkg::MaxName:0] rowv_q;

  logic [LW-1:0] tlen_q, clen_q, i_q, r_q, pj_q;
  logic          tovf_q, pv_q, last_q, fin_q, bfound_q, out_valid_q;
  logic [7:0]    prev_q, ci_q, t_rd_q, t_jm2_q;
  logic [IW-1:0] cnt_q, bidx_q;
  logic [LW-1:0] bdist_q, dist_q;
  logic [LW-1:0] rl_rd_q, rb_rd_q, rl_jm1_q, rb_d1_q, rb_d2_q, cur_prev_q;
  logic          rlv_q;
  nned_pkg::out_res_t res_q;

  logic [7:0]    ch;
  logic          issue, wr;
  logic [LW-1:0] rl_j, cur, dmin, a_sub, a_del, a_ins, a_tr;
  logic          trans;

  assign ch    = nned_pkg::fold(in_req_i.character);
  assign issue = cmd_i.row && (r_q <= tlen_q);
  assign wr    = cmd_i.row && pv_q;

  // One column of the alignment recurrence.
  always_comb begin
    rl_j  = rlv_q ? rl_rd_q : pj_q;
    a_sub = rl_jm1_q + ((ci_q != t_rd_q) ? LW'(1) : LW'(0));
    a_del = rl_j + LW'(1);
    a_ins = cur_prev_q + LW'(1);
    a_tr  = rb_d2_q + LW'(1);
    trans = (i_q > LW'(1)) && (pj_q > LW'(1)) && (ci_q == t_jm2_q) && (prev_q == t_rd_q);
    dmin  = a_sub;
    if (a_del < dmin) dmin = a_del;
    if (a_ins < dmin) dmin = a_ins;
    if (trans && a_tr < dmin) dmin = a_tr;
    cur   = (pj_q == '0) ? i_q : dmin;
  end

  // Result of a finished candidate.
  logic          too_long, no_target, acc;
  logic [LW-1:0] cand_dist, longer, budget;
  logic [14:0]   prod;

  always_comb begin
    too_long  = clen_q > LW'(nned_pkg::MaxName);
    no_target = (tlen_q == '0) || tovf_q;
    cand_dist = '0;
    if (!too_long && !no_target) cand_dist = (clen_q == '0) ? tlen_q : dist_q;
    longer    = (clen_q > tlen_q) ? clen_q : tlen_q;
    prod      = 15'(longer) * 15'(nned_pkg::Div3Mul);
    budget    = (longer < LW'(3)) ? LW'(1) : LW'(prod >> nned_pkg::Div3Sh);
    acc       = !too_long && !no_target && (cand_dist <= budget) && (cand_dist < bdist_q);
  end

  // Memories: registered reads, one write port each.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && in_req_i.cmd == nned_pkg::CMD_TGT && clen_q == '0 &&
        tlen_q < LW'(nned_pkg::MaxName)) begin
      tmem[tlen_q[5:0]] <= ch;
    end
    if (issue) begin
      rl_rd_q <= rl_mem[r_q];
      rb_rd_q <= rb_mem[r_q];
      t_rd_q  <= tmem[6'(r_q - LW'(1))];
    end
    if (wr) begin
      rl_mem[pj_q] <= cur;
      rb_mem[pj_q] <= rl_j;
    end
  end

  // Column pipeline payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      ci_q   <= ch;
      last_q <= in_req_i.last;
      fin_q  <= in_req_i.final_candidate;
      i_q    <= clen_q + LW'(1);
    end
    if (wr) begin
      rl_jm1_q   <= rl_j;
      rb_d1_q    <= rb_rd_q;
      rb_d2_q    <= rb_d1_q;
      t_jm2_q    <= t_rd_q;
      cur_prev_q <= cur;
      if (pj_q == tlen_q) dist_q <= cur;
    end
    if (cmd_i.finish) begin
      res_q.candidate_index <= cnt_q;
      res_q.distance        <= cand_dist;
      res_q.too_long        <= too_long;
      res_q.no_target       <= no_target;
      res_q.accepted        <= acc;
      res_q.best_valid      <= bfound_q || acc;
      res_q.best_index      <= acc ? cnt_q : (bfound_q ? bidx_q : '0);
      res_q.best_distance   <= acc ? cand_dist : (bfound_q ? bdist_q : '0);
      res_q.list_done       <= fin_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rowv_q      <= '0;
      tlen_q      <= '0;
      tovf_q      <= 1'b0;
      clen_q      <= '0;
      prev_q      <= '0;
      cnt_q       <= '0;
      bidx_q      <= '0;
      bdist_q     <= '1;
      bfound_q    <= 1'b0;
      r_q         <= '0;
      pj_q        <= '0;
      pv_q        <= 1'b0;
      rlv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.take) begin
        case (in_req_i.cmd)
          nned_pkg::CMD_NEW: begin
            rowv_q   <= '0;
            tlen_q   <= '0;
            tovf_q   <= 1'b0;
            clen_q   <= '0;
            prev_q   <= '0;
            cnt_q    <= '0;
            bidx_q   <= '0;
            bdist_q  <= '1;
            bfound_q <= 1'b0;
          end
          nned_pkg::CMD_TGT: begin
            if (clen_q == '0) begin
              if (tlen_q < LW'(nned_pkg::MaxName)) tlen_q <= tlen_q + LW'(1);
              else tovf_q <= 1'b1;
            end
          end
          nned_pkg::CMD_CHR: begin
            if (clen_q < LW'(nned_pkg::MaxName)) clen_q <= clen_q + LW'(1);
            else clen_q <= LW'(nned_pkg::MaxName + 1);
          end
          default: ;
        endcase
      end
      if (cmd_i.start) begin
        r_q  <= '0;
        pv_q <= 1'b0;
      end else if (cmd_i.row) begin
        pv_q <= issue;
        if (issue) begin
          r_q   <= r_q + LW'(1);
          pj_q  <= r_q;
          rlv_q <= rowv_q[r_q];
        end
      end
      if (wr) begin
        rowv_q[pj_q] <= 1'b1;
        if (pj_q == tlen_q) prev_q <= ci_q;
      end
      if (cmd_i.finish) begin
        if (acc) begin
          bfound_q <= 1'b1;
          bidx_q   <= cnt_q;
          bdist_q  <= cand_dist;
        end
        cnt_q  <= cnt_q + IW'(1);
        clen_q <= '0;
        prev_q <= '0;
        rowv_q <= '0;
      end
    end
  end

  assign stat_o.loop_done = wr && (pj_q == tlen_q);
  assign stat_o.cand_full = clen_q >= LW'(nned_pkg::MaxName);
  assign stat_o.last      = last_q;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign out_res_o        = res_q;

endmodule

[rtl/nearest_name_edit_distance.sv]
// Nearest-name search by case-insensitive optimal string alignment distance.
// A candidate character is worked one column per cycle through the row memories,
// plus a read and a hand-off; a closing request also loads the result register.
// Reset (rst_ni low, asynchronous) empties the query: no target, no best, count 0.
`include "nearest_name_edit_distance_assert.svh"

// Top level: joins the controller and the datapath. The controller takes one
// request at a time and sequences the row update and the result hand-off; the
// datapath holds the target string, the previous two rows of the alignment
// table in small memories, and the result register that decouples the output.
// A new request is taken while an earlier result still waits on the output.
module nearest_name_edit_distance (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  nned_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output nned_pkg::out_res_t out_res_o
);

  nned_pkg::ctrl_cmd_t ctrl_cmd;
  nned_pkg::dp_stat_t  dp_stat;

  // The controller sees the command code and the last flag of the request.
  nned_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (in_req_i.cmd),
    .last_i     (in_req_i.last),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  // The datapath does all the storage and arithmetic.
  nned_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (ctrl_cmd),
    .stat_o      (dp_stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

  // An accepted candidate must be reported as the current best.
  `NNED_ASSERT_IMP(a_acc_best, out_valid_o && out_res_o.accepted,
    out_res_o.best_valid && out_res_o.best_distance == out_res_o.distance &&
    out_res_o.best_index == out_res_o.candidate_index, "accepted result is not the best")
  // Skipped or unmatched candidates are never accepted and carry no distance.
  `NNED_ASSERT_IMP(a_skip, out_valid_o && (out_res_o.too_long || out_res_o.no_target),
    !out_res_o.accepted && out_res_o.distance == '0, "skipped candidate carries a match")
  // A new result is only loaded when the old one has left.
  `NNED_ASSERT_NXT(a_no_overwrite, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_res_o), "pending result overwritten")

endmodule

[tb/nearest_name_edit_distance_tb.sv]
// Self-checking testbench for the nearest-name edit distance block.
// Depends on nned_pkg for the request and result types and the command codes.
module nearest_name_edit_distance_tb;

  localparam int NameLimit = 64;
  localparam int IdxMod    = 65536;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  nned_pkg::in_req_t  in_req_i;
  logic               out_valid_o;
  logic               out_ready_i;
  nned_pkg::out_res_t out_res_o;

  nearest_name_edit_distance DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Predictor state for the alignment search, sized to the block's name limit.
  logic [7:0]  tgt_str [NameLimit];
  int          tgt_len;
  bit          tgt_over;
  int          row_prev [NameLimit+1];
  int          row_prev2 [NameLimit+1];
  int          cand_len;
  logic [7:0]  last_char;
  int          cand_count;
  int          best_pos;
  int          best_cost;
  bit          have_best;

  // Pending requests for the driver, and results the predictor expects.
  nned_pkg::in_req_t  pending_reqs[$];
  nned_pkg::out_res_t expected_results[$];

  int  mismatches;
  // Idle percentages, switched between phases of the stimulus.
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_off;           // long receiver hold-off in cycles
  bit  in_taken;           // the offered request was accepted at the last rising edge

  function automatic logic [7:0] lower_case(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  function automatic void reset_rows();
    for (int j = 0; j <= NameLimit; j++) row_prev[j] = j;
  endfunction

  function automatic void clear_query();
    for (int j = 0; j < NameLimit; j++) tgt_str[j] = 8'h00;
    for (int j = 0; j <= NameLimit; j++) row_prev2[j] = 0;
    reset_rows();
    tgt_len = 0; tgt_over = 0; cand_len = 0; last_char = 8'h00;
    cand_count = 0; best_pos = 0; best_cost = 127; have_best = 0;
  endfunction

  // Adds one candidate character as a new row of the alignment table.
  function automatic void add_char(logic [7:0] ci);
    int cur [NameLimit+1];
    int i, d;
    i = cand_len + 1;
    cur[0] = i;
    for (int j = 1; j <= tgt_len; j++) begin
      d = row_prev[j-1] + ((ci == tgt_str[j-1]) ? 0 : 1);
      if (row_prev[j] + 1 < d) d = row_prev[j] + 1;
      if (cur[j-1] + 1 < d) d = cur[j-1] + 1;
      // Adjacent transposition of the last two characters.
      if (i > 1 && j > 1 && ci == tgt_str[j-2] && last_char == tgt_str[j-1] &&
          row_prev2[j-2] + 1 < d) d = row_prev2[j-2] + 1;
      cur[j] = d;
    end
    for (int j = 0; j <= tgt_len; j++) begin
      row_prev2[j] = row_prev[j];
      row_prev[j] = cur[j];
    end
  endfunction

  function automatic nned_pkg::out_res_t close_candidate(logic fin);
    nned_pkg::out_res_t r;
    bit long_c, no_tgt, acc;
    int cost, longer, budget;
    long_c = cand_len > NameLimit;
    no_tgt = (tgt_len == 0) || tgt_over;
    cost = 0; acc = 0;
    if (!long_c && !no_tgt) begin
      cost = row_prev[tgt_len];
      longer = (cand_len > tgt_len) ? cand_len : tgt_len;
      budget = (longer < 3) ? 1 : longer / 3;
      if (cost <= budget && cost < best_cost) begin
        acc = 1; best_cost = cost; best_pos = cand_count; have_best = 1;
      end
    end
    r.candidate_index = cand_count[15:0];
    r.distance        = cost[6:0];
    r.too_long        = long_c;
    r.no_target       = no_tgt;
    r.accepted        = acc;
    r.best_valid      = have_best;
    r.best_index      = have_best ? best_pos[15:0] : '0;
    r.best_distance   = have_best ? best_cost[6:0] : '0;
    r.list_done       = fin;
    cand_count = (cand_count + 1) % IdxMod;
    cand_len = 0; last_char = 8'h00;
    reset_rows();
    return r;
  endfunction

  // Runs one accepted request through the predictor.
  function automatic void predict_request(nned_pkg::in_req_t q);
    logic [7:0] ch;
    ch = lower_case(q.character);
    case (q.cmd)
      nned_pkg::CMD_NEW: clear_query();
      nned_pkg::CMD_TGT: begin
        if (cand_len == 0) begin
          if (tgt_len < NameLimit) begin
            tgt_str[tgt_len] = ch;
            tgt_len++;
            row_prev[tgt_len] = tgt_len;
          end else begin
            tgt_over = 1;
          end
        end
      end
      nned_pkg::CMD_END: expected_results.push_back(close_candidate(q.final_candidate));
      default: begin
        if (cand_len < NameLimit) begin
          add_char(ch);
          cand_len++;
          last_char = ch;
        end else begin
          cand_len = NameLimit + 1;
        end
        if (q.last) expected_results.push_back(close_candidate(q.final_candidate));
      end
    endcase
  endfunction

  // Driver: offers the queued requests at the falling edge; valid holds until taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        in_taken = 1'b0;
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_req_i   <= pending_reqs.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness, with an optional long hold-off counted down here.
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off    <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts accepted requests and checks results at the rising edge.
  always @(posedge clk_i) begin
    nned_pkg::out_res_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_request(in_req_i);
        in_taken = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: %p", out_res_o);
        end else begin
          want = expected_results.pop_front();
          if (out_res_o !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p, got %p", want, out_res_o);
          end
        end
      end
    end
  end

  function automatic nned_pkg::in_req_t mk(nned_pkg::cmd_e c, logic [7:0] ch, logic l,
                                           logic f);
    nned_pkg::in_req_t q;
    q.cmd = c; q.character = ch; q.last = l; q.final_candidate = f;
    return q;
  endfunction

  task automatic push_name(nned_pkg::cmd_e c, string s, logic f);
    for (int k = 0; k < s.len(); k++)
      pending_reqs.push_back(mk(c, s[k], (c == nned_pkg::CMD_CHR) && (k == s.len()-1), f));
  endtask

  // Random letter, mostly from a small alphabet so that names lie close together.
  function automatic logic [7:0] rand_char();
    int r;
    r = $urandom_range(99);
    if (r < 80)
      return 8'(8'h61 + $urandom_range(3) - (($urandom_range(1)) ? 8'h20 : 8'h00));
    return 8'($urandom_range(255));
  endfunction

  // A query: a target, then candidates that are mostly edits of that target.
  task automatic push_query(int max_len, int n_cand);
    logic [7:0] tgt [$];
    logic [7:0] cand [$];
    int tl, p;
    pending_reqs.push_back(mk(nned_pkg::CMD_NEW, 8'($urandom_range(255)),
                              1'($urandom_range(1)), 1'($urandom_range(1))));
    tl = $urandom_range(max_len, 0);
    for (int k = 0; k < tl; k++) begin
      tgt.push_back(rand_char());
      pending_reqs.push_back(mk(nned_pkg::CMD_TGT, tgt[k], 1'($urandom_range(1)),
                                1'($urandom_range(1))));
    end
    for (int c = 0; c < n_cand; c++) begin
      cand = tgt;
      for (int e = $urandom_range(2); e > 0; e--) begin
        p = (cand.size() > 0) ? $urandom_range(cand.size()-1) : 0;
        case ($urandom_range(3))
          0: cand.insert(p, rand_char());
          1: if (cand.size() > 0) cand.delete(p);
          2: if (cand.size() > 0) cand[p] = rand_char();
          default: if (p + 1 < cand.size()) begin
            logic [7:0] t;
            t = cand[p]; cand[p] = cand[p+1]; cand[p+1] = t;
          end
        endcase
      end
      if ($urandom_range(9) == 0) begin
        // Noise: a stray target character and a random-length junk name.
        pending_reqs.push_back(mk(nned_pkg::CMD_TGT, rand_char(), 1'b0, 1'b0));
        cand.delete();
        for (int k = $urandom_range(8); k > 0; k--) cand.push_back(8'($urandom_range(255)));
      end
      if (cand.size() == 0 || $urandom_range(7) == 0) begin
        foreach (cand[k])
          pending_reqs.push_back(mk(nned_pkg::CMD_CHR, cand[k], 1'b0,
                                    1'($urandom_range(1))));
        pending_reqs.push_back(mk(nned_pkg::CMD_END, 8'($urandom_range(255)),
                                  1'($urandom_range(1)), c == n_cand-1));
      end else begin
        foreach (cand[k])
          pending_reqs.push_back(mk(nned_pkg::CMD_CHR, cand[k], k == cand.size()-1,
                                    (k == cand.size()-1) ? (c == n_cand-1) : 1'b0));
      end
    end
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
  endtask

  string long_name;

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    out_ready_i = 1'b0;
    in_taken = 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_off = 0;
    mismatches = 0;
    clear_query();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed: no target, case folding, transposition, empty names, a stray
    // target character in a candidate, and names over the limit.
    push_name(nned_pkg::CMD_CHR, "ab", 1'b0);
    pending_reqs.push_back(mk(nned_pkg::CMD_END, 8'hFF, 1'b1, 1'b1));
    pending_reqs.push_back(mk(nned_pkg::CMD_NEW, 8'h00, 1'b0, 1'b0));
    push_name(nned_pkg::CMD_TGT, "Abcd", 1'b0);
    push_name(nned_pkg::CMD_CHR, "abdc", 1'b0);
    push_name(nned_pkg::CMD_CHR, "ABCD", 1'b0);
    pending_reqs.push_back(mk(nned_pkg::CMD_CHR, 8'h61, 1'b0, 1'b0));
    pending_reqs.push_back(mk(nned_pkg::CMD_TGT, 8'hFF, 1'b1, 1'b1));
    pending_reqs.push_back(mk(nned_pkg::CMD_END, 8'h00, 1'b0, 1'b0));
    push_name(nned_pkg::CMD_CHR, "\xff\x80", 1'b1);
    drain();
    long_name = "";
    for (int k = 0; k < 66; k++) long_name = {long_name, "z"};
    pending_reqs.push_back(mk(nned_pkg::CMD_NEW, 8'h00, 1'b0, 1'b0));
    push_name(nned_pkg::CMD_TGT, long_name.substr(0, 63), 1'b0);
    push_name(nned_pkg::CMD_CHR, long_name, 1'b0);
    push_name(nned_pkg::CMD_CHR, long_name.substr(0, 63), 1'b0);
    push_name(nned_pkg::CMD_TGT, "z", 1'b0);
    push_name(nned_pkg::CMD_CHR, "z", 1'b1);

    // Random phases with different idle patterns. The second phase holds the
    // receiver off for a long stretch so that the block backs up its input.
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      send_idle_pct  = (ph == 1 || ph == 3) ? 50 : 0;
      recv_stall_pct = (ph == 2) ? 50 : (ph == 3) ? 16 : 0;
      if (ph == 3) send_idle_pct = 16;
      if (ph == 1) hold_off = 400;
      for (int n = 0; n < 12; n++) begin
        push_query(($urandom_range(19) == 0) ? 64 : 8, $urandom_range(6, 1));
        if ($urandom_range(4) == 0) begin
          // Stretches with no idling inside a phase.
          drain();
          send_idle_pct = 0; recv_stall_pct = 0;
        end
      end
    end
    drain();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Overall time limit.
  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
